// ----- hdl/gss_pkg.sv -----
package gss_pkg;

	// widths fixed by the item and register fields
	localparam int CFG_WIDTH   = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int GEAR_W      = 3;
	localparam int SAMPLE_W    = 12;
	localparam int OPCODE_W    = 3;

	// defaults for the top level parameters
	localparam int TIMER_BITS_DEF = 16;
	localparam int GEAR_COUNT_DEF = 6;

	// highest sample that still decodes, and the largest number of gears decoded
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 12'd1023;
	localparam int                  GEAR_LIMIT = 6;

	// descending sensor thresholds, gear i lies between entries i and i+1
	localparam logic [SAMPLE_W-1:0] SENS_TABLE [7] = '{
		12'd1023, 12'd950, 12'd800, 12'd510, 12'd340, 12'd170, 12'd0
	};

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UP_CLUTCH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_GEAR     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_CUT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_CLUTCH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_GEAR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL_WAIT = 3'd5;

	// configuration reset values
	localparam logic [CFG_WIDTH-1:0] UP_CLUTCH_RST    = 16'd50;
	localparam logic [CFG_WIDTH-1:0] UP_GEAR_RST      = 16'd100;
	localparam logic [CFG_WIDTH-1:0] UP_CUT_RST       = 16'd150;
	localparam logic [CFG_WIDTH-1:0] DOWN_CLUTCH_RST  = 16'd50;
	localparam logic [CFG_WIDTH-1:0] DOWN_GEAR_RST    = 16'd100;
	localparam logic [CFG_WIDTH-1:0] NEUTRAL_WAIT_RST = 16'd500;

	// bit positions of the solenoid drive word
	localparam int DRV_CUT    = 0;
	localparam int DRV_CLUTCH = 1;
	localparam int DRV_UP     = 2;
	localparam int DRV_DOWN   = 3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_TICK       = 3'd0,
		OP_UP         = 3'd1,
		OP_DOWN       = 3'd2,
		OP_NEUTRAL    = 3'd3,
		OP_CLUTCH_ON  = 3'd4,
		OP_CLUTCH_OFF = 3'd5,
		OP_SAMPLE     = 3'd6
	} op_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_UP_A = 3'd1,
		PH_UP_B = 3'd2,
		PH_UP_C = 3'd3,
		PH_DN_A = 3'd4,
		PH_DN_B = 3'd5,
		PH_WAIT = 3'd6
	} phase_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] up_clutch;
		logic [CFG_WIDTH-1:0] up_gear;
		logic [CFG_WIDTH-1:0] up_cut;
		logic [CFG_WIDTH-1:0] down_clutch;
		logic [CFG_WIDTH-1:0] down_gear;
		logic [CFG_WIDTH-1:0] neutral_wait;
	} cfg_t;

	// release and timeout conditions for one timer value
	typedef struct packed {
		logic up_clutch;
		logic up_gear;
		logic up_cut;
		logic down_clutch;
		logic down_gear;
		logic wait_out;
	} cmp_t;

	// sequencer state carried through the release chain
	typedef struct packed {
		phase_t      phase;
		logic        zero;
		logic [3:0]  drv;
		logic [GEAR_W-1:0] gear_before;
		logic [1:0]  fail_count;
		logic        neutral;
		logic        fail_flag;
		logic        done;
	} adv_t;

	// one result item
	typedef struct packed {
		logic              cut;
		logic              clutch;
		logic              up;
		logic              down;
		logic [GEAR_W-1:0] gear;
		logic              busy;
		logic              failed;
	} res_t;

	// sample to gear, lowest matching entry wins, out of range keeps the gear
	function automatic logic [GEAR_W-1:0] gear_decode(
		input logic [SAMPLE_W-1:0] s,
		input logic [GEAR_W-1:0]   cur,
		input int                  gear_count
	);
		logic [GEAR_W-1:0] g;
		g = cur;
		if (s <= SAMPLE_MAX) begin
			for (int i = GEAR_LIMIT - 1; i >= 0; i--) begin
				if (i < gear_count && SENS_TABLE[i] >= s && s >= SENS_TABLE[i+1]) begin
					g = GEAR_W'(i);
				end
			end
		end
		return g;
	endfunction

	// one release step of the sequencer; zero selects the restarted timer
	function automatic adv_t adv_step(
		input adv_t              a,
		input cmp_t              ct,
		input cmp_t              cz,
		input logic [GEAR_W-1:0] gear
	);
		adv_t n;
		cmp_t c;
		n = a;
		c = a.zero ? cz : ct;
		if (!a.done) begin
			unique case (a.phase)
				PH_UP_A: begin
					if (!c.up_clutch) begin
						n.done = 1'b1;
					end else begin
						n.drv[DRV_CLUTCH] = 1'b0;
						n.phase = PH_UP_B;
					end
				end
				PH_UP_B: begin
					if (!c.up_gear) begin
						n.done = 1'b1;
					end else begin
						n.drv[DRV_UP] = 1'b0;
						n.phase = PH_UP_C;
					end
				end
				PH_UP_C: begin
					if (c.up_cut) begin
						n.drv[DRV_CUT] = 1'b0;
						n.phase = PH_IDLE;
					end
					n.done = 1'b1;
				end
				PH_DN_A: begin
					if (!c.down_clutch) begin
						n.done = 1'b1;
					end else begin
						n.drv[DRV_CLUTCH] = 1'b0;
						n.phase = PH_DN_B;
					end
				end
				PH_DN_B: begin
					if (!c.down_gear) begin
						n.done = 1'b1;
					end else begin
						n.drv[DRV_DOWN] = 1'b0;
						if (a.neutral) begin
							n.phase = PH_WAIT;
							n.zero = 1'b1;
						end else begin
							n.phase = PH_IDLE;
							n.done = 1'b1;
						end
					end
				end
				PH_WAIT: begin
					if (gear != a.gear_before) begin
						if (gear == '0) begin
							n.phase = PH_IDLE;
							n.neutral = 1'b0;
							n.done = 1'b1;
						end else begin
							n.gear_before = gear;
							n.drv[DRV_CLUTCH] = 1'b1;
							n.drv[DRV_DOWN] = 1'b1;
							n.zero = 1'b1;
							n.phase = PH_DN_A;
						end
					end else if (!c.wait_out) begin
						n.done = 1'b1;
					end else begin
						n.fail_count = a.fail_count + 2'd1;
						if (n.fail_count == 2'd3) begin
							n.fail_flag = 1'b1;
							n.phase = PH_IDLE;
							n.neutral = 1'b0;
							n.done = 1'b1;
						end else begin
							n.gear_before = gear;
							n.drv[DRV_CLUTCH] = 1'b1;
							n.drv[DRV_DOWN] = 1'b1;
							n.zero = 1'b1;
							n.phase = PH_DN_A;
						end
					end
				end
				default: begin
					n.phase = PH_IDLE;
					n.done = 1'b1;
				end
			endcase
		end
		return n;
	endfunction

endpackage

// ----- hdl/gss_cfg.sv -----
module gss_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gss_pkg::CFG_WIDTH-1:0]    cfg_wdata,
	output gss_pkg::cfg_t                    cfg
);

	gss_pkg::cfg_t cfg_q;

	// register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_clutch    <= gss_pkg::UP_CLUTCH_RST;
			cfg_q.up_gear      <= gss_pkg::UP_GEAR_RST;
			cfg_q.up_cut       <= gss_pkg::UP_CUT_RST;
			cfg_q.down_clutch  <= gss_pkg::DOWN_CLUTCH_RST;
			cfg_q.down_gear    <= gss_pkg::DOWN_GEAR_RST;
			cfg_q.neutral_wait <= gss_pkg::NEUTRAL_WAIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gss_pkg::CFG_UP_CLUTCH:    cfg_q.up_clutch    <= cfg_wdata;
				gss_pkg::CFG_UP_GEAR:      cfg_q.up_gear      <= cfg_wdata;
				gss_pkg::CFG_UP_CUT:       cfg_q.up_cut       <= cfg_wdata;
				gss_pkg::CFG_DOWN_CLUTCH:  cfg_q.down_clutch  <= cfg_wdata;
				gss_pkg::CFG_DOWN_GEAR:    cfg_q.down_gear    <= cfg_wdata;
				gss_pkg::CFG_NEUTRAL_WAIT: cfg_q.neutral_wait <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/gss_core.sv -----
module gss_core #(
	parameter int TIMER_BITS = gss_pkg::TIMER_BITS_DEF,
	parameter int GEAR_COUNT = gss_pkg::GEAR_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            acc,
	input  logic [gss_pkg::OPCODE_W-1:0]    opcode,
	input  logic [gss_pkg::SAMPLE_W-1:0]    sensor_sample,
	input  gss_pkg::cfg_t                   cfg,
	output gss_pkg::res_t                   res
);

	// compare width covers both the timer and the 16-bit registers
	localparam int CW = (TIMER_BITS > gss_pkg::CFG_WIDTH) ? TIMER_BITS : gss_pkg::CFG_WIDTH;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
	// longest release chain: two downshift passes around a wait
	localparam int STEPS = 6;

	gss_pkg::phase_t           phase_q;
	logic [TIMER_BITS-1:0]     phase_timer_q;
	logic [gss_pkg::GEAR_W-1:0] gear_q;
	logic [gss_pkg::GEAR_W-1:0] gear_before_q;
	logic [1:0]                fail_count_q;
	logic                      neutral_q;
	logic                      fail_flag_q;
	logic [3:0]                drv_q;

	logic [TIMER_BITS-1:0]     t_step;
	logic [TIMER_BITS-1:0]     timer_nx;
	logic [gss_pkg::GEAR_W-1:0] gear_nx;
	logic                      idle;
	logic [CW-1:0]             t_ext;
	logic                      t_full;
	gss_pkg::adv_t             start;
	gss_pkg::adv_t             chain [STEPS+1];
	gss_pkg::adv_t             fin;
	gss_pkg::cmp_t             ct;
	gss_pkg::cmp_t             cz;

	assign idle = (phase_q == gss_pkg::PH_IDLE);

	// command decode, tick and sample handling
	always_comb begin
		t_step = phase_timer_q;
		gear_nx = gear_q;
		start.phase = phase_q;
		start.zero = 1'b0;
		start.drv = drv_q;
		start.gear_before = gear_before_q;
		start.fail_count = fail_count_q;
		start.neutral = neutral_q;
		start.fail_flag = fail_flag_q;
		start.done = 1'b0;
		unique case (gss_pkg::op_t'(opcode))
			gss_pkg::OP_TICK: begin
				if (!idle && phase_timer_q != TMAX) begin
					t_step = phase_timer_q + TIMER_BITS'(1);
				end
			end
			gss_pkg::OP_UP: begin
				if (idle) begin
					start.drv[gss_pkg::DRV_CUT] = 1'b1;
					start.drv[gss_pkg::DRV_CLUTCH] = 1'b1;
					start.drv[gss_pkg::DRV_UP] = 1'b1;
					start.zero = 1'b1;
					start.phase = gss_pkg::PH_UP_A;
				end
			end
			gss_pkg::OP_DOWN: begin
				if (idle) begin
					start.neutral = 1'b0;
					start.drv[gss_pkg::DRV_CLUTCH] = 1'b1;
					start.drv[gss_pkg::DRV_DOWN] = 1'b1;
					start.zero = 1'b1;
					start.phase = gss_pkg::PH_DN_A;
				end
			end
			gss_pkg::OP_NEUTRAL: begin
				if (idle && gear_q != '0) begin
					start.neutral = 1'b1;
					start.fail_count = 2'd0;
					start.fail_flag = 1'b0;
					start.gear_before = gear_q;
					start.drv[gss_pkg::DRV_CLUTCH] = 1'b1;
					start.drv[gss_pkg::DRV_DOWN] = 1'b1;
					start.zero = 1'b1;
					start.phase = gss_pkg::PH_DN_A;
				end
			end
			gss_pkg::OP_CLUTCH_ON:  start.drv[gss_pkg::DRV_CLUTCH] = 1'b1;
			gss_pkg::OP_CLUTCH_OFF: start.drv[gss_pkg::DRV_CLUTCH] = 1'b0;
			gss_pkg::OP_SAMPLE: begin
				gear_nx = gss_pkg::gear_decode(sensor_sample, gear_q, GEAR_COUNT);
			end
			default: begin
			end
		endcase
	end

	// release and timeout compares, a full timer meets every clamped threshold
	assign t_ext = CW'(t_step);
	assign t_full = (t_step == TMAX);
	assign ct.up_clutch   = (t_ext >= CW'(cfg.up_clutch)) || t_full;
	assign ct.up_gear     = (t_ext >= CW'(cfg.up_gear)) || t_full;
	assign ct.up_cut      = (t_ext >= CW'(cfg.up_cut)) || t_full;
	assign ct.down_clutch = (t_ext >= CW'(cfg.down_clutch)) || t_full;
	assign ct.down_gear   = (t_ext >= CW'(cfg.down_gear)) || t_full;
	assign ct.wait_out    = (t_ext > CW'(cfg.neutral_wait)) || t_full;

	// same compares with a freshly restarted timer
	assign cz.up_clutch   = (cfg.up_clutch == '0);
	assign cz.up_gear     = (cfg.up_gear == '0);
	assign cz.up_cut      = (cfg.up_cut == '0);
	assign cz.down_clutch = (cfg.down_clutch == '0);
	assign cz.down_gear   = (cfg.down_gear == '0);
	assign cz.wait_out    = 1'b0;

	// release chain, each stage one phase step
	always_comb begin
		chain[0] = start;
		for (int i = 0; i < STEPS; i++) begin
			chain[i+1] = gss_pkg::adv_step(chain[i], ct, cz, gear_nx);
		end
	end

	assign fin = chain[STEPS];
	assign timer_nx = fin.zero ? '0 : t_step;

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gss_pkg::PH_IDLE;
			phase_timer_q <= '0;
			gear_q <= '0;
			gear_before_q <= '0;
			fail_count_q <= '0;
			neutral_q <= 1'b0;
			fail_flag_q <= 1'b0;
			drv_q <= '0;
		end else if (acc) begin
			phase_q <= fin.phase;
			phase_timer_q <= timer_nx;
			gear_q <= gear_nx;
			gear_before_q <= fin.gear_before;
			fail_count_q <= fin.fail_count;
			neutral_q <= fin.neutral;
			fail_flag_q <= fin.fail_flag;
			drv_q <= fin.drv;
		end
	end

	// result of this transfer, the state after the step
	assign res.cut = fin.drv[gss_pkg::DRV_CUT];
	assign res.clutch = fin.drv[gss_pkg::DRV_CLUTCH];
	assign res.up = fin.drv[gss_pkg::DRV_UP];
	assign res.down = fin.drv[gss_pkg::DRV_DOWN];
	assign res.gear = gear_nx;
	assign res.busy = (fin.phase != gss_pkg::PH_IDLE);
	assign res.failed = fin.fail_flag;

`ifndef SYNTHESIS
	a_idle_not_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == gss_pkg::PH_IDLE |-> !neutral_q)
		else $error("auto-neutral mode left on while idle");

	a_down_only_in_down: assert property (@(posedge clk) disable iff (!arst_n)
		drv_q[gss_pkg::DRV_DOWN] |-> (phase_q == gss_pkg::PH_DN_A || phase_q == gss_pkg::PH_DN_B))
		else $error("down solenoid on outside a downshift");

	a_up_only_in_up: assert property (@(posedge clk) disable iff (!arst_n)
		drv_q[gss_pkg::DRV_UP] |-> (phase_q == gss_pkg::PH_UP_A || phase_q == gss_pkg::PH_UP_B))
		else $error("up solenoid on outside an upshift");

	a_fail_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fail_count_q == 2'd3 |-> fail_flag_q)
		else $error("failure count at three without the give-up flag");

	a_timer_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		acc && phase_q == gss_pkg::PH_IDLE && opcode == gss_pkg::OP_TICK
		|=> $stable(phase_timer_q))
		else $error("timer moved on an idle tick");
`endif

endmodule

// ----- hdl/gss_out_buf.sv -----
module gss_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  gss_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output gss_pkg::res_t out_data
);

	logic          main_valid_q;
	gss_pkg::res_t main_q;
	logic          spare_valid_q;
	gss_pkg::res_t spare_q;
	logic          pop;

	assign pop = main_valid_q && !out_stall;
	assign full = spare_valid_q;

	// output register with a skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (!main_valid_q || pop) begin
			if (spare_valid_q) begin
				main_valid_q <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			spare_valid_q <= 1'b1;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (!main_valid_q || pop) begin
			main_q <= spare_valid_q ? spare_q : push_data;
		end else if (push) begin
			spare_q <= push_data;
		end
	end

	assign out_valid = main_valid_q;
	assign out_data = main_q;

`ifndef SYNTHESIS
	a_spare_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q |-> main_valid_q)
		else $error("skid entry held with an empty output register");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		main_valid_q && out_stall && push |=> spare_valid_q)
		else $error("transfer lost while output stalled");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		spare_valid_q && !out_stall |=> main_q == $past(spare_q))
		else $error("skid entry not moved to the output");
`endif

endmodule

// ----- hdl/gearshift_solenoid_sequencer.sv -----
// a result is registered in the output register, or in the skid entry behind it while the output stalls
// throughput: one item per cycle while in_stall is low; the state update and its release chain
//   are combinational between the state registers and the output register
// a two-entry output buffer keeps taking items while one result waits
// reset: arst_n clears the sequencer to idle, gear neutral, all drives off,
//   and loads the default phase times
module gearshift_solenoid_sequencer #(
	parameter int TIMER_BITS = gss_pkg::TIMER_BITS_DEF,
	parameter int GEAR_COUNT = gss_pkg::GEAR_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [gss_pkg::OPCODE_W-1:0]    opcode,
	input  logic [gss_pkg::SAMPLE_W-1:0]    sensor_sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            cut_drive,
	output logic                            clutch_drive,
	output logic                            up_drive,
	output logic                            down_drive,
	output logic [gss_pkg::GEAR_W-1:0]      gear_now,
	output logic                            busy_res,
	output logic                            neutral_failed,
	input  logic                            cfg_we,
	input  logic [gss_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gss_pkg::CFG_WIDTH-1:0]   cfg_wdata
);

	gss_pkg::cfg_t cfg;
	gss_pkg::res_t res;
	gss_pkg::res_t out_data;
	logic          acc;
	logic          full;

	// input transfer
	assign in_stall = full;
	assign acc = in_valid && !full;

	gss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gss_core #(
		.TIMER_BITS (TIMER_BITS),
		.GEAR_COUNT (GEAR_COUNT)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.opcode        (opcode),
		.sensor_sample (sensor_sample),
		.cfg           (cfg),
		.res           (res)
	);

	gss_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// result fields
	assign cut_drive = out_data.cut;
	assign clutch_drive = out_data.clutch;
	assign up_drive = out_data.up;
	assign down_drive = out_data.down;
	assign gear_now = out_data.gear;
	assign busy_res = out_data.busy;
	assign neutral_failed = out_data.failed;

endmodule
